>>> hw/rtl/oaht_pkg.sv
// Shared types, codes and defaults for the open-addressed hash table core.
// Used by the controller, the datapath and the top level; no dependencies.
package oaht_pkg;

    // parameter defaults
    localparam int TABLE_ENTRIES_DEF = 101;
    localparam int MAX_PROBES_DEF    = 20;
    localparam int KEY_BYTES_DEF     = 15;

    // linear term of the probe polynomial j*j + 23*j
    localparam int PROBE_LINEAR = 23;

    // fixed field geometry
    localparam int KEY_BYTES_MAX = 15;
    localparam int KEY_W         = 8 * KEY_BYTES_MAX;
    localparam int BYTE_IDX_W    = 4;

    // operation codes
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_ADD_FAIL  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_REM_MISS  = 3'd5;

    typedef logic [6:0] slot_t;
    typedef logic [KEY_BYTES_MAX-1:0][7:0] key_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  key_length;
        logic [63:0] key_lo;
        logic [55:0] key_hi;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        slot_t      slot;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic hash;
        logic modr;
        logic probe;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic mod_last;
        logic op_none;
        logic hit;
        logic miss;
    } dp_sts_t;

endpackage

>>> hw/rtl/open_addressing_hash_table_core.sv
// Open-addressed hash table of keys of up to 15 bytes with quadratic probing.
// After reset the core sweeps the table once to clear the occupied flags, with
// req_stall high. Each request then holds req_stall high through byte-serial
// hashing, the remainder by the table size (a reciprocal multiply for the
// quotient, then a multiply and subtract), probing until a probe ends the search
// (or MAX_PROBES probes are spent; an unused kind skips probing) and the hand-off
// of the result to the output register, which waits while the previous result
// still sits stalled there. Probing is bound by the single read port of the
// table memory, one slot per cycle. A finished result waits in the output
// register while the next request is taken. Depends on oaht_pkg, oaht_ctrl,
// oaht_datapath and oaht_ram.
module open_addressing_hash_table_core #(
    parameter int TABLE_ENTRIES = oaht_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = oaht_pkg::MAX_PROBES_DEF,
    parameter int KEY_BYTES     = oaht_pkg::KEY_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  oaht_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output oaht_pkg::out_item_t rsp
);

    oaht_pkg::dp_cmd_t cmd;
    oaht_pkg::dp_sts_t sts;

    // sequencer
    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // hashing, probing and table storage
    oaht_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_PROBES    (MAX_PROBES),
        .KEY_BYTES     (KEY_BYTES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    // a probe ends either on a hit or on a miss, never both
    a_single_end: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.hit && sts.miss))
        else $error("probe reported hit and miss together");

    // a result only enters a free or draining output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid || !rsp_stall))
        else $error("result loaded over a pending output beat");

    // the core is busy right after taking a request
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> req_stall)
        else $error("request channel open while an item is in work");

    // a new output beat comes only from a result load
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.out_load))
        else $error("output beat without a result load");

endmodule

>>> hw/rtl/oaht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/oaht_ctrl.sv
// Sequencer of the hash table core: clear sweep, hash, remainder, probe, result.
// Depends on oaht_pkg for the command and status structs.
module oaht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output oaht_pkg::dp_cmd_t cmd,
    input  oaht_pkg::dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_PROBE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.modr = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = sts.op_none ? S_DONE : S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
                if (sts.hit || sts.miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

>>> hw/rtl/oaht_datapath.sv
// Datapath of the hash table core: key capture, byte-serial hash, reciprocal
// remainder, probe address walk, table memory and result registers.
// Depends on oaht_pkg and oaht_ram.
module oaht_datapath #(
    parameter int TABLE_ENTRIES = oaht_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = oaht_pkg::MAX_PROBES_DEF,
    parameter int KEY_BYTES     = oaht_pkg::KEY_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oaht_pkg::in_item_t  req,
    input  oaht_pkg::dp_cmd_t   cmd,
    output oaht_pkg::dp_sts_t   sts,
    output oaht_pkg::out_item_t rsp
);

    localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
    localparam int SUM_MAX    = 255 * KEY_BYTES * (KEY_BYTES + 1) / 2;
    localparam int SUM_W      = $clog2(SUM_MAX + 1);
    localparam int PC_W       = $clog2(MAX_PROBES + 1);
    localparam int STEP_FIRST = (1 + oaht_pkg::PROBE_LINEAR) % TABLE_ENTRIES;
    localparam int BI_W       = oaht_pkg::BYTE_IDX_W;
    localparam int MEM_W      = oaht_pkg::KEY_W + 1;

    // rounded-up reciprocal of the table size, exact quotient for any sum below 2**SUM_W
    localparam int     RECIP_SH = SUM_W + SLOT_W;
    localparam longint RECIP_L  = ((longint'(1) << RECIP_SH) + longint'(TABLE_ENTRIES) - 1)
                                  / longint'(TABLE_ENTRIES);
    localparam int     PROD_W   = 2 * SUM_W + SLOT_W + 1;

    localparam logic [SUM_W:0]  RECIP     = (SUM_W + 1)'(RECIP_L);
    localparam logic [SLOT_W:0] ENTRIES_X = (SLOT_W + 1)'(TABLE_ENTRIES);

    // operation and key
    logic [1:0]        kind_reg;
    oaht_pkg::key_t    key_reg;
    oaht_pkg::key_t    key_raw;
    oaht_pkg::key_t    key_masked;
    logic [BI_W-1:0]   n_eff;

    // hash and remainder
    logic [BI_W-1:0]   hidx_reg;
    logic [BI_W-1:0]   weight;
    logic [7:0]        byte_sel;
    logic [11:0]       prod;
    logic [SUM_W-1:0]  sum_reg;
    logic              mstep_reg;
    logic [PROD_W-1:0] recip_prod;
    logic [SUM_W-1:0]  quot_reg;
    logic [PROD_W-1:0] quot_prod;
    logic [SLOT_W-1:0] rem_next;

    // probe walk
    logic [SLOT_W-1:0] pos_reg;
    logic [SLOT_W-1:0] step_reg;
    logic [SLOT_W:0]   ps_sum;
    logic [SLOT_W:0]   st_sum;
    logic [SLOT_W-1:0] next_addr;
    logic [SLOT_W-1:0] step_nx;
    logic [PC_W-1:0]   pc_reg;
    logic              inflight_reg;
    logic [SLOT_W-1:0] addr_q_reg;
    logic              issue_ok;
    logic              occ;
    logic              key_eq;
    logic              cond;
    logic              hit;

    // clear sweep
    logic [SLOT_W-1:0] clr_reg;

    // results
    oaht_pkg::out_item_t res_reg;
    oaht_pkg::out_item_t rsp_reg;
    logic [2:0]          hit_status;
    logic [2:0]          miss_status;

    // table memory
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [MEM_W-1:0]  wr_data;
    logic              rd_en;
    logic [MEM_W-1:0]  rd_data;

    // key length saturation and masking of unused bytes
    always_comb
    begin
        n_eff   = (req.key_length > BI_W'(KEY_BYTES)) ? BI_W'(KEY_BYTES) : req.key_length;
        key_raw = {req.key_hi, req.key_lo};
        for (int i = 0; i < oaht_pkg::KEY_BYTES_MAX; i++)
        begin
            key_masked[i] = (BI_W'(i) < n_eff) ? key_raw[i] : 8'd0;
        end
    end

    // one weighted byte per cycle
    assign weight   = hidx_reg + BI_W'(1);
    assign byte_sel = key_reg[hidx_reg];
    assign prod     = {8'd0, weight} * {4'd0, byte_sel};

    // remainder: quotient by reciprocal, then sum minus quotient times size
    assign recip_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign quot_prod  = PROD_W'(quot_reg) * PROD_W'(ENTRIES_X);
    assign rem_next   = SLOT_W'(sum_reg - quot_prod[SUM_W-1:0]);

    // next probe slot: step grows by two per probe
    assign ps_sum    = {1'b0, pos_reg} + {1'b0, step_reg};
    assign next_addr = (ps_sum >= ENTRIES_X) ? SLOT_W'(ps_sum - ENTRIES_X) : SLOT_W'(ps_sum);
    assign st_sum    = {1'b0, step_reg} + (SLOT_W + 1)'(2);
    assign step_nx   = (st_sum >= ENTRIES_X) ? SLOT_W'(st_sum - ENTRIES_X) : SLOT_W'(st_sum);
    assign issue_ok  = (pc_reg != PC_W'(MAX_PROBES));

    // slot check on returning read data
    assign occ    = rd_data[oaht_pkg::KEY_W];
    assign key_eq = (rd_data[oaht_pkg::KEY_W-1:0] == key_reg);
    assign cond   = (kind_reg == oaht_pkg::KIND_ADD) ? !occ : (occ && key_eq);
    assign hit    = inflight_reg && cond;

    // status codes by operation
    always_comb
    begin
        unique case (kind_reg)
            oaht_pkg::KIND_ADD:
            begin
                hit_status  = oaht_pkg::ST_INSERTED;
                miss_status = oaht_pkg::ST_ADD_FAIL;
            end
            oaht_pkg::KIND_REMOVE:
            begin
                hit_status  = oaht_pkg::ST_REMOVED;
                miss_status = oaht_pkg::ST_REM_MISS;
            end
            default:
            begin
                hit_status  = oaht_pkg::ST_FOUND;
                miss_status = oaht_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // status to controller
    always_comb
    begin
        sts.clear_last = (clr_reg == SLOT_W'(TABLE_ENTRIES - 1));
        sts.hash_last  = (hidx_reg == BI_W'(KEY_BYTES - 1));
        sts.mod_last   = mstep_reg;
        sts.op_none    = (kind_reg != oaht_pkg::KIND_ADD) &&
                         (kind_reg != oaht_pkg::KIND_REMOVE) &&
                         (kind_reg != oaht_pkg::KIND_FIND);
        sts.hit        = hit;
        sts.miss       = inflight_reg && !cond && !issue_ok;
    end

    // memory ports: clear sweep or commit of an add or remove
    always_comb
    begin
        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd.probe && hit && (kind_reg != oaht_pkg::KIND_FIND);
            wr_addr = addr_q_reg;
            wr_data = {(kind_reg == oaht_pkg::KIND_ADD), key_reg};
        end
    end

    assign rd_en = cmd.probe && issue_ok;

    oaht_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (next_addr),
        .rd_data (rd_data)
    );

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            hidx_reg     <= '0;
            mstep_reg    <= 1'b0;
            pc_reg       <= '0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= cmd.probe && issue_ok;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.load)
            begin
                hidx_reg  <= '0;
                mstep_reg <= 1'b0;
                pc_reg    <= '0;
            end
            if (cmd.hash)
            begin
                hidx_reg <= hidx_reg + BI_W'(1);
            end
            if (cmd.modr)
            begin
                mstep_reg <= 1'b1;
            end
            if (cmd.probe && issue_ok)
            begin
                pc_reg <= pc_reg + PC_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.kind;
            key_reg  <= key_masked;
            sum_reg  <= '0;
            pos_reg  <= '0;
            step_reg <= SLOT_W'(STEP_FIRST);
        end
        if (cmd.hash)
        begin
            sum_reg <= sum_reg + SUM_W'(prod);
        end
        if (cmd.modr)
        begin
            quot_reg <= recip_prod[RECIP_SH +: SUM_W];
            if (sts.mod_last)
            begin
                pos_reg        <= rem_next;
                res_reg.status <= miss_status;
                res_reg.slot   <= '0;
            end
        end
        if (cmd.probe)
        begin
            if (issue_ok)
            begin
                pos_reg    <= next_addr;
                step_reg   <= step_nx;
                addr_q_reg <= next_addr;
            end
            if (hit)
            begin
                res_reg.status <= hit_status;
                res_reg.slot   <= oaht_pkg::slot_t'(addr_q_reg);
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule
